/* hdl/coin_register_change_maker_defines.svh */
// Assertion macros shared by the coin register change maker RTL.
// No dependencies; expects i_clk and i_rst_n in the including module.
`ifndef COIN_REGISTER_CHANGE_MAKER_DEFINES_SVH
`define COIN_REGISTER_CHANGE_MAKER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define CRCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crcm: same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define CRCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crcm: next-cycle check failed");

`endif

/* hdl/crcm_pkg.sv */
// Package for the coin register change maker: operation codes, denomination
// tables and the controller/datapath command and status structs. No dependencies.
`default_nettype none

package crcm_pkg;

    localparam int DENOM_N = 8;
    localparam int IDX_W   = $clog2(DENOM_N);
    localparam int QTY_W   = 8;
    localparam int AMT_W   = 16;
    localparam int VAL_W   = 10;
    localparam int RCP_W   = 17;
    localparam int SH_W    = 5;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHANGE = 2'd2;

    // index 0 = 5c ... index 7 = $10, values in cents
    localparam logic [VAL_W-1:0] DENOM_VALUE [DENOM_N] = '{
        10'd5, 10'd10, 10'd20, 10'd50, 10'd100, 10'd200, 10'd500, 10'd1000
    };

    // floor(n / d) == (n * RECIP) >> SHIFT, exact for every 16-bit n
    localparam logic [RCP_W-1:0] DENOM_RECIP [DENOM_N] = '{
        17'd104858, 17'd104858, 17'd104858, 17'd83887,
        17'd83887,  17'd83887,  17'd67109,  17'd67109
    };

    localparam logic [SH_W-1:0] DENOM_SHIFT [DENOM_N] = '{
        5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26
    };

    typedef struct packed {
        logic start;
        logic apply;
        logic mul;
        logic take;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_change;
        logic last;
    } t_dp_sts;

endpackage

`default_nettype wire

/* hdl/crcm_ctrl.sv */
// Controller FSM for the coin register change maker.
// Depends on crcm_pkg and coin_register_change_maker_defines.svh.
`default_nettype none
`include "coin_register_change_maker_defines.svh"

module crcm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire logic             i_stall,
    input  wire crcm_pkg::t_dp_sts i_sts,
    output crcm_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_APPLY = 5'b00010,
        S_MUL   = 5'b00100,
        S_TAKE  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    crcm_pkg::t_dp_cmd cmd;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.start = 1'b1;
                    n_state   = S_APPLY;
                end
            end
            S_APPLY: begin
                if (i_sts.is_change) begin
                    n_state = S_MUL;
                end else begin
                    cmd.apply = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_TAKE;
            end
            S_TAKE: begin
                cmd.take = 1'b1;
                n_state  = i_sts.last ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = cmd.load_out || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `CRCM_ASSERT_NEXT(a_accept_starts_work, i_valid && !o_stall, r_state == S_APPLY)
    `CRCM_ASSERT_NOW(a_load_into_free_slot, cmd.load_out, !r_out_valid || !i_stall)
    `CRCM_ASSERT_NEXT(a_load_raises_valid, cmd.load_out, r_out_valid)

endmodule

`default_nettype wire

/* hdl/crcm_dp.sv */
// Datapath for the coin register change maker: stock registers, lane-parallel
// insert/remove, one-denomination-per-pass change step, result registers.
// Depends on crcm_pkg and coin_register_change_maker_defines.svh.
`default_nettype none
`include "coin_register_change_maker_defines.svh"

module crcm_dp #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire crcm_pkg::t_dp_cmd                          i_cmd,
    output crcm_pkg::t_dp_sts                               o_sts,
    input  wire logic [1:0]                                 i_kind,
    input  wire logic [crcm_pkg::DENOM_N-1:0][crcm_pkg::QTY_W-1:0] i_qty,
    input  wire logic [crcm_pkg::AMT_W-1:0]                 i_amount,
    output logic [crcm_pkg::DENOM_N-1:0][crcm_pkg::AMT_W-1:0] o_chg,
    output logic                                            o_ok,
    output logic [crcm_pkg::AMT_W-1:0]                      o_shortfall
);

    localparam int DN    = crcm_pkg::DENOM_N;
    localparam int AW    = crcm_pkg::AMT_W;
    localparam int CMP_W = (COUNT_BITS > AW) ? COUNT_BITS : AW;
    localparam int PRD_W = AW + crcm_pkg::RCP_W;
    localparam int DED_W = AW + crcm_pkg::VAL_W;
    localparam logic [crcm_pkg::IDX_W-1:0] IDX_LAST = crcm_pkg::IDX_W'(DN - 1);

    logic [COUNT_BITS-1:0]         r_stock [DN];
    logic [1:0]                    r_kind;
    logic [DN-1:0][crcm_pkg::QTY_W-1:0] r_qty;
    logic [AW-1:0]                 r_rem;
    logic [AW-1:0]                 r_want;
    logic [crcm_pkg::IDX_W-1:0]    r_idx;
    logic [DN-1:0][AW-1:0]         r_paid;
    logic                          r_uflow;
    logic [DN-1:0][AW-1:0]         r_out_chg;
    logic                          r_out_ok;
    logic [AW-1:0]                 r_out_short;

    // insert/remove lanes
    logic [COUNT_BITS:0]           ins_sum [DN];
    logic [COUNT_BITS-1:0]         n_stock [DN];
    logic [DN-1:0]                 lane_uf;

    always_comb begin
        for (int i = 0; i < DN; i++) begin
            ins_sum[i] = {1'b0, r_stock[i]} + (COUNT_BITS + 1)'(r_qty[i]);
            lane_uf[i] = (COUNT_BITS'(r_qty[i]) > r_stock[i]);
            case (r_kind)
                crcm_pkg::KIND_INSERT:
                    n_stock[i] = ins_sum[i][COUNT_BITS] ? '1 : ins_sum[i][COUNT_BITS-1:0];
                crcm_pkg::KIND_REMOVE:
                    n_stock[i] = lane_uf[i] ? '0 : r_stock[i] - COUNT_BITS'(r_qty[i]);
                default:
                    n_stock[i] = r_stock[i];
            endcase
        end
    end

    // change step: quotient by reciprocal, then min against stock
    logic [PRD_W-1:0] prod;
    logic [AW-1:0]    want_c;
    logic [CMP_W-1:0] want_w, stock_w, take_w;
    logic [AW-1:0]    take;
    logic [DED_W-1:0] deduct;

    assign prod    = PRD_W'(r_rem) * PRD_W'(crcm_pkg::DENOM_RECIP[r_idx]);
    assign want_c  = AW'(prod >> crcm_pkg::DENOM_SHIFT[r_idx]);
    assign want_w  = CMP_W'(r_want);
    assign stock_w = CMP_W'(r_stock[r_idx]);
    assign take_w  = (want_w < stock_w) ? want_w : stock_w;
    assign take    = AW'(take_w);
    assign deduct  = DED_W'(take) * DED_W'(crcm_pkg::DENOM_VALUE[r_idx]);

    logic          ok_c;
    logic [AW-1:0] short_c;

    always_comb begin
        case (r_kind)
            crcm_pkg::KIND_INSERT: ok_c = 1'b1;
            crcm_pkg::KIND_REMOVE: ok_c = !r_uflow;
            crcm_pkg::KIND_CHANGE: ok_c = (r_rem == '0);
            default:               ok_c = 1'b0;
        endcase
        short_c = (r_kind == crcm_pkg::KIND_CHANGE) ? r_rem : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DN; i++) begin
                r_stock[i] <= '0;
            end
            r_out_chg   <= '0;
            r_out_ok    <= 1'b0;
            r_out_short <= '0;
        end else begin
            if (i_cmd.apply) begin
                for (int i = 0; i < DN; i++) begin
                    r_stock[i] <= n_stock[i];
                end
            end
            if (i_cmd.take) begin
                r_stock[r_idx] <= r_stock[r_idx] - COUNT_BITS'(take_w);
            end
            if (i_cmd.load_out) begin
                r_out_chg   <= r_paid;
                r_out_ok    <= ok_c;
                r_out_short <= short_c;
            end
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind  <= i_kind;
            r_qty   <= i_qty;
            r_rem   <= i_amount;
            r_idx   <= IDX_LAST;
            r_paid  <= '0;
            r_uflow <= 1'b0;
        end
        if (i_cmd.apply) begin
            r_uflow <= (r_kind == crcm_pkg::KIND_REMOVE) && (|lane_uf);
        end
        if (i_cmd.mul) begin
            r_want <= want_c;
        end
        if (i_cmd.take) begin
            r_paid[r_idx] <= take;
            r_rem         <= r_rem - AW'(deduct);
            r_idx         <= r_idx - crcm_pkg::IDX_W'(1);
        end
    end

    assign o_sts.is_change = (r_kind == crcm_pkg::KIND_CHANGE);
    assign o_sts.last      = (r_idx == '0);
    assign o_chg           = r_out_chg;
    assign o_ok            = r_out_ok;
    assign o_shortfall     = r_out_short;

    `CRCM_ASSERT_NOW(a_deduct_within_rem, i_cmd.take, deduct <= DED_W'(r_rem))
    `CRCM_ASSERT_NEXT(a_short_clears_ok, i_cmd.load_out, (o_shortfall == '0) || !o_ok)
    `CRCM_ASSERT_NEXT(a_start_from_top_denom, i_cmd.start, r_idx == IDX_LAST)

endmodule

`default_nettype wire

/* hdl/coin_register_change_maker.sv */
// Top level of the coin register change maker: controller plus datapath.
// Depends on crcm_pkg, crcm_ctrl and crcm_dp.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------
//  request | i_valid | o_stall | i_kind, i_qty_5c .. i_qty_10d, i_amount
//  result  | o_valid | i_stall | o_change_5c .. o_change_10d, o_ok, o_shortfall
//
// Insert, remove and unused kinds go through latch, one lane-parallel update
// of all eight stock counts, then result load.
// Make change goes through latch, dispatch, then per denomination a reciprocal
// multiply, then min against stock and deduct, using the single shared
// quotient/deduct unit walking $10 down to 5c, then load.
// Requests are taken only while the controller is idle; one result register
// decouples the sides, so a new request is accepted while a result waits.
// A finished request holds the block in its final state while the earlier result is still stalled.
// Synchronous active-low reset clears all stock counts to zero at once.
`default_nettype none

module coin_register_change_maker #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_qty_5c,
    input  wire logic [7:0]  i_qty_10c,
    input  wire logic [7:0]  i_qty_20c,
    input  wire logic [7:0]  i_qty_50c,
    input  wire logic [7:0]  i_qty_1d,
    input  wire logic [7:0]  i_qty_2d,
    input  wire logic [7:0]  i_qty_5d,
    input  wire logic [7:0]  i_qty_10d,
    input  wire logic [15:0] i_amount,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [13:0]      o_change_5c,
    output logic [12:0]      o_change_10c,
    output logic [11:0]      o_change_20c,
    output logic [10:0]      o_change_50c,
    output logic [9:0]       o_change_1d,
    output logic [8:0]       o_change_2d,
    output logic [7:0]       o_change_5d,
    output logic [6:0]       o_change_10d,
    output logic             o_ok,
    output logic [15:0]      o_shortfall
);

    crcm_pkg::t_dp_cmd cmd;
    crcm_pkg::t_dp_sts sts;

    // lane 0 = 5c, lane 7 = $10
    logic [crcm_pkg::DENOM_N-1:0][crcm_pkg::QTY_W-1:0] qty;
    logic [crcm_pkg::DENOM_N-1:0][crcm_pkg::AMT_W-1:0] chg;

    assign qty = {i_qty_10d, i_qty_5d, i_qty_2d, i_qty_1d,
                  i_qty_50c, i_qty_20c, i_qty_10c, i_qty_5c};

    crcm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    crcm_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_kind      (i_kind),
        .i_qty       (qty),
        .i_amount    (i_amount),
        .o_chg       (chg),
        .o_ok        (o_ok),
        .o_shortfall (o_shortfall)
    );

    // paid counts never exceed 65535 / value, so these selects lose nothing
    assign o_change_5c  = chg[0][13:0];
    assign o_change_10c = chg[1][12:0];
    assign o_change_20c = chg[2][11:0];
    assign o_change_50c = chg[3][10:0];
    assign o_change_1d  = chg[4][9:0];
    assign o_change_2d  = chg[5][8:0];
    assign o_change_5d  = chg[6][7:0];
    assign o_change_10d = chg[7][6:0];

endmodule

`default_nettype wire
